FILE: hdl/alkd_pkg.sv
package alkd_pkg;

  // Width of every threshold register.
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_S1_LO   = 3'd0,
    REG_S1_HI   = 3'd1,
    REG_S2_LO   = 3'd2,
    REG_S2_HI   = 3'd3,
    REG_S3_LO   = 3'd4,
    REG_S3_HI   = 3'd5,
    REG_RELEASE = 3'd6
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] RST_S1_LO   = 13'd455;
  localparam logic [CFG_W-1:0] RST_S1_HI   = 13'd683;
  localparam logic [CFG_W-1:0] RST_S2_LO   = 13'd910;
  localparam logic [CFG_W-1:0] RST_S2_HI   = 13'd1252;
  localparam logic [CFG_W-1:0] RST_S3_LO   = 13'd11;
  localparam logic [CFG_W-1:0] RST_S3_HI   = 13'd342;
  localparam logic [CFG_W-1:0] RST_RELEASE = 13'd3413;

  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_S1   = 2'd1,
    KEY_S2   = 2'd2,
    KEY_S3   = 2'd3
  } key_t;

  typedef struct packed {
    logic [CFG_W-1:0] s1_lo;
    logic [CFG_W-1:0] s1_hi;
    logic [CFG_W-1:0] s2_lo;
    logic [CFG_W-1:0] s2_hi;
    logic [CFG_W-1:0] s3_lo;
    logic [CFG_W-1:0] s3_hi;
    logic [CFG_W-1:0] release_lvl;
  } cfg_t;

  typedef struct packed {
    key_t key;
    logic held;
  } decision_t;

endpackage

FILE: hdl/alkd_classify.sv
module alkd_classify #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0] burst_max,
  input  logic [SAMPLE_BITS-1:0] burst_min,
  input  alkd_pkg::cfg_t         cfg,
  input  logic                   latch_in,
  output alkd_pkg::decision_t    decision
);
  import alkd_pkg::*;

  localparam int unsigned CMP_W = (SAMPLE_BITS + 1 > CFG_W) ? SAMPLE_BITS + 1 : CFG_W;

  logic [CMP_W-1:0] sum;
  logic             hit1, hit2, hit3, above_release;
  key_t             hit;

  assign sum = CMP_W'(burst_max) + CMP_W'(burst_min);

  assign hit1 = (sum > CMP_W'(cfg.s1_lo)) && (sum < CMP_W'(cfg.s1_hi));
  assign hit2 = (sum > CMP_W'(cfg.s2_lo)) && (sum < CMP_W'(cfg.s2_hi));
  assign hit3 = (sum > CMP_W'(cfg.s3_lo)) && (sum < CMP_W'(cfg.s3_hi));
  assign above_release = sum > CMP_W'(cfg.release_lvl);

  always_comb begin
    if (hit1) begin
      hit = KEY_S1;
    end else if (hit2) begin
      hit = KEY_S2;
    end else if (hit3) begin
      hit = KEY_S3;
    end else begin
      hit = KEY_NONE;
    end
  end

  // A window hit reports only on a fresh press; the release test applies only
  // when no window matched.
  always_comb begin
    decision.key  = KEY_NONE;
    decision.held = latch_in;
    if (hit != KEY_NONE) begin
      decision.held = 1'b1;
      if (!latch_in) begin
        decision.key = hit;
      end
    end else if (above_release) begin
      decision.held = 1'b0;
    end
  end

endmodule

FILE: hdl/adc_ladder_key_decoder_top.sv
// A result enters the output register when the request that ends a burst (or
// carries a read error) leaves the input register. One sample request per
// cycle, set by the single processing stage between the input register and
// the output register; a burst end or read error waits while the slot is full.
// Reset (synchronous, active low) clears the burst, the press latch and both
// valid flags, and loads the threshold registers with their default values.
module adc_ladder_key_decoder_top #(
  parameter int unsigned BURST_LEN   = 64,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // sample in the low SAMPLE_BITS bits, zero fill above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  // bit 0: read_error
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // bits 1:0 key_event, bit 2 key_held, bits 7:3 zero
  output logic [7:0]                           out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [alkd_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [alkd_pkg::CFG_W-1:0]           cfg_wdata
);
  import alkd_pkg::*;

  localparam int unsigned CNT_W = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BURST_LEN - 1);

  cfg_t                   cfg_r;
  logic                   in_vld_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic                   err_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt, min_r, min_nxt;
  logic                   latch_r, latch_nxt;
  logic                   out_vld_r, out_vld_nxt;
  key_t                   key_r, key_nxt;
  logic                   held_r, held_nxt;
  logic [SAMPLE_BITS-1:0] upd_max, upd_min;
  logic                   last, produces, out_free, advance, load_out;
  decision_t              decision;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.s1_lo       <= RST_S1_LO;
      cfg_r.s1_hi       <= RST_S1_HI;
      cfg_r.s2_lo       <= RST_S2_LO;
      cfg_r.s2_hi       <= RST_S2_HI;
      cfg_r.s3_lo       <= RST_S3_LO;
      cfg_r.s3_hi       <= RST_S3_HI;
      cfg_r.release_lvl <= RST_RELEASE;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_S1_LO:   cfg_r.s1_lo       <= cfg_wdata;
        REG_S1_HI:   cfg_r.s1_hi       <= cfg_wdata;
        REG_S2_LO:   cfg_r.s2_lo       <= cfg_wdata;
        REG_S2_HI:   cfg_r.s2_hi       <= cfg_wdata;
        REG_S3_LO:   cfg_r.s3_lo       <= cfg_wdata;
        REG_S3_HI:   cfg_r.s3_hi       <= cfg_wdata;
        REG_RELEASE: cfg_r.release_lvl <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The input register drains unless its request needs the output slot and
  // that slot is still occupied.
  assign last      = (cnt_r == CNT_LAST);
  assign produces  = err_r || last;
  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && (!produces || out_free);
  assign load_out  = advance && produces;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      smp_r <= in_tdata[SAMPLE_BITS-1:0];
      err_r <= in_tuser[0];
    end
  end

  assign upd_max = (smp_r > max_r) ? smp_r : max_r;
  assign upd_min = (smp_r < min_r) ? smp_r : min_r;

  alkd_classify #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_classify (
    .burst_max (upd_max),
    .burst_min (upd_min),
    .cfg       (cfg_r),
    .latch_in  (latch_r),
    .decision  (decision)
  );

  always_comb begin
    cnt_nxt   = cnt_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    latch_nxt = latch_r;
    key_nxt   = key_r;
    held_nxt  = held_r;
    if (advance) begin
      if (err_r) begin
        cnt_nxt  = '0;
        max_nxt  = '0;
        min_nxt  = '1;
        key_nxt  = KEY_NONE;
        held_nxt = latch_r;
      end else if (last) begin
        cnt_nxt   = '0;
        max_nxt   = '0;
        min_nxt   = '1;
        latch_nxt = decision.held;
        key_nxt   = decision.key;
        held_nxt  = decision.held;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        max_nxt = upd_max;
        min_nxt = upd_min;
      end
    end
  end

  always_comb begin
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      max_r     <= '0;
      min_r     <= '1;
      latch_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      latch_r   <= latch_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    held_r <= held_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, held_r, key_r};

`ifndef SYNTHESIS
  // A reported key always leaves the press latch set.
  a_key_sets_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (key_r != KEY_NONE) |-> held_r)
    else $error("key event reported without held flag");

  // The latch only rises when a key event is loaded into the output.
  a_latch_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(latch_r) |-> out_vld_r && (key_r != KEY_NONE))
    else $error("press latch set without a key event");

  // A burst end or a read error restarts the sample count.
  a_burst_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (cnt_r == '0))
    else $error("sample count not cleared after burst end");

  // Within a running burst the minimum never exceeds the maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (min_r <= max_r))
    else $error("burst minimum above burst maximum");
`endif

endmodule
